[hw/rtl/ctc_pkg.sv]
// Shared types, result codes and keyword tables for the token classifier.
// No dependencies; imported by every module of the block.
package ctc_pkg;

  localparam int MAX_KEYWORD_LEN   = 7;
  localparam int NUM_KEYWORDS      = 16;
  localparam int QUEUE_DEPTH_DFLT  = 4;

  typedef logic [2:0] kind_t;

  localparam kind_t K_RESERVED = 3'd0;
  localparam kind_t K_INTEGER  = 3'd1;
  localparam kind_t K_FLOAT    = 3'd2;
  localparam kind_t K_OPERATOR = 3'd3;
  localparam kind_t K_IDENT    = 3'd4;
  localparam kind_t K_EOS      = 3'd5;
  localparam kind_t K_ERROR    = 3'd6;

  // One queued event: a token kind, optionally followed by end of statement.
  typedef struct packed {
    logic  two;
    kind_t kind;
  } event_t;

  // Front to queue push.
  typedef struct packed {
    logic   valid;
    event_t ev;
  } event_push_t;

  // Queue to back head view.
  typedef struct packed {
    logic   avail;
    event_t ev;
  } event_head_t;

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0:    n = 4'd5;
      4'd1:    n = 4'd4;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd5;
      4'd4:    n = 4'd6;
      4'd5:    n = 4'd4;
      4'd6:    n = 4'd6;
      4'd7:    n = 4'd6;
      4'd8:    n = 4'd4;
      4'd9:    n = 4'd4;
      4'd10:   n = 4'd6;
      4'd11:   n = 4'd6;
      4'd12:   n = 4'd5;
      4'd13:   n = 4'd7;
      4'd14:   n = 4'd5;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  // Character pos of keyword k; text is space padded to eight bytes.
  function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [2:0] pos);
    logic [63:0] s;
    logic [5:0]  base;
    case (k)
      4'd0:    s = "const   ";
      4'd1:    s = "char    ";
      4'd2:    s = "int     ";
      4'd3:    s = "float   ";
      4'd4:    s = "double  ";
      4'd5:    s = "long    ";
      4'd6:    s = "static  ";
      4'd7:    s = "struct  ";
      4'd8:    s = "void    ";
      4'd9:    s = "enum    ";
      4'd10:   s = "extern  ";
      4'd11:   s = "return  ";
      4'd12:   s = "break   ";
      4'd13:   s = "typedef ";
      4'd14:   s = "union   ";
      default: s = "goto    ";
    endcase
    base = {3'd7 - pos, 3'b000};
    return s[base +: 8];
  endfunction

endpackage

[hw/rtl/ctc_front.sv]
// Front end: accepts characters, tracks the pending token and classifies it.
// Depends on ctc_pkg; pushes events into ctc_queue.
module ctc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                end_of_input,
  output ctc_pkg::event_push_t push_ev
);
  import ctc_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_INTDOT  = 3'd2;
  localparam logic [2:0] PH_DOT     = 3'd3;
  localparam logic [2:0] PH_DOTFRAC = 3'd4;
  localparam logic [2:0] PH_OP      = 3'd5;
  localparam logic [2:0] PH_IDENT   = 3'd6;
  localparam logic [2:0] PH_BAD     = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [7:0]  first_ch, first_ch_next;
  logic [3:0]  token_length, token_length_next;
  logic [15:0] cands, cands_next;
  logic        halted, halted_next;

  logic        c_digit, c_alpha, c_op, c_space, c_semi, c_dot;
  logic [15:0] keep, len_hit;
  kind_t       tok_kind;
  logic [2:0]  add_phase;

  assign c_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign c_alpha = (ch == 8'h5F) || ((ch >= 8'h41) && (ch <= 8'h5A)) ||
                   ((ch >= 8'h61) && (ch <= 8'h7A));
  assign c_op    = (ch == 8'h2B) || (ch == 8'h2D) || (ch == 8'h2A) || (ch == 8'h2F) ||
                   (ch == 8'h3D) || (ch == 8'h21) || (ch == 8'h3C) || (ch == 8'h3E);
  assign c_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  assign c_semi  = (ch == 8'h3B);
  assign c_dot   = (ch == 8'h2E);

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      len_hit[k] = (kw_len(4'(k)) == token_length);
      keep[k]    = ({1'b0, token_length} < 5'(MAX_KEYWORD_LEN)) &&
                   (token_length < kw_len(4'(k))) &&
                   (kw_byte(4'(k), token_length[2:0]) == ch);
    end
  end

  always_comb begin
    case (phase)
      PH_INT:     tok_kind = K_INTEGER;
      PH_INTDOT:  tok_kind = K_FLOAT;
      PH_DOTFRAC: tok_kind = K_FLOAT;
      PH_OP:      tok_kind = K_OPERATOR;
      PH_IDENT:   tok_kind = |(cands & len_hit) ? K_RESERVED : K_IDENT;
      default:    tok_kind = K_ERROR;
    endcase
  end

  // Phase after appending ch to the pending token.
  always_comb begin
    add_phase = phase;
    case (phase)
      PH_IDLE: begin
        if (c_digit)      add_phase = PH_INT;
        else if (c_dot)   add_phase = PH_DOT;
        else if (c_op)    add_phase = PH_OP;
        else if (c_alpha) add_phase = PH_IDENT;
        else              add_phase = PH_BAD;
      end
      PH_INT: begin
        if (c_dot)         add_phase = PH_INTDOT;
        else if (!c_digit) add_phase = PH_BAD;
      end
      PH_INTDOT: begin
        if (!c_digit) add_phase = PH_BAD;
      end
      PH_DOT, PH_DOTFRAC: begin
        add_phase = c_digit ? PH_DOTFRAC : PH_BAD;
      end
      PH_OP: begin
        if (!((token_length == 4'd1) && (ch == 8'h3D) &&
              ((first_ch == 8'h3D) || (first_ch == 8'h3C) ||
               (first_ch == 8'h3E) || (first_ch == 8'h21))))
          add_phase = PH_BAD;
      end
      PH_IDENT: begin
        if (!(c_alpha || c_digit)) add_phase = PH_BAD;
      end
      default: add_phase = PH_BAD;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    first_ch_next     = first_ch;
    token_length_next = token_length;
    cands_next        = cands;
    halted_next       = halted;
    push_ev           = '0;
    if (accept && !halted) begin
      if (end_of_input || c_space || c_semi) begin
        if (phase != PH_IDLE) begin
          push_ev.valid   = 1'b1;
          push_ev.ev.kind = tok_kind;
          push_ev.ev.two  = c_semi && !end_of_input && (tok_kind != K_ERROR);
          if (tok_kind == K_ERROR) halted_next = 1'b1;
        end else if (c_semi && !end_of_input) begin
          push_ev.valid   = 1'b1;
          push_ev.ev.kind = K_EOS;
        end
        phase_next        = PH_IDLE;
        first_ch_next     = '0;
        token_length_next = '0;
        cands_next        = '1;
      end else begin
        if (phase == PH_IDLE) first_ch_next = ch;
        phase_next = add_phase;
        cands_next = (add_phase == PH_IDENT) ? (cands & keep) : '0;
        if (token_length != 4'd15) token_length_next = token_length + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      first_ch     <= '0;
      token_length <= '0;
      cands        <= '1;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      first_ch     <= first_ch_next;
      token_length <= token_length_next;
      cands        <= cands_next;
      halted       <= halted_next;
    end
  end

endmodule

[hw/rtl/ctc_queue.sv]
// Small event queue decoupling the classifier from the result output stage.
// Depends on ctc_pkg for the event types.
module ctc_queue #(
  parameter int DEPTH = ctc_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctc_pkg::event_push_t push_ev,
  input  logic                 take,
  output ctc_pkg::event_head_t head,
  output logic                 full
);
  import ctc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  event_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full       = (count == CW'(DEPTH));
  assign head.avail = (count != '0);
  assign head.ev    = slots[rd_ptr];
  assign do_wr      = push_ev.valid;
  assign do_rd      = take && head.avail;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= push_ev.ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/ctc_back.sv]
// Back end: expands queued events into result transactions in a register.
// Depends on ctc_pkg; drains ctc_queue.
module ctc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ctc_pkg::event_head_t head,
  output logic                 take,
  input  logic                 pop,
  output logic                 empty,
  output logic [2:0]           kind,
  output logic                 last
);
  import ctc_pkg::*;

  logic out_valid;
  logic eos_owed;
  logic out_free;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign take     = out_free && !eos_owed && head.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      eos_owed  <= 1'b0;
    end else if (out_free) begin
      if (eos_owed) begin
        out_valid <= 1'b1;
        eos_owed  <= 1'b0;
      end else begin
        out_valid <= head.avail;
        eos_owed  <= head.avail && head.ev.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (eos_owed) begin
        kind <= K_EOS;
        last <= 1'b1;
      end else begin
        kind <= head.ev.kind;
        last <= !head.ev.two;
      end
    end
  end

endmodule

[hw/rtl/c_token_classifier.sv]
// Top level of the streaming token classifier: front, event queue, back.
// Depends on ctc_pkg, ctc_front, ctc_queue and ctc_back.
//
//   channel  | handshake    | fields
//   ---------+--------------+------------------------
//   input    | push / full  | ch[7:0], end_of_input
//   result   | empty / pop  | kind[2:0], last
//
// One character is taken per cycle while full is low; a semicolon after a
// token makes two results, which the output register drains one per cycle
// while pop is high. A result passes through the event queue and then the
// output register before it reaches the ports.
// full rises only when the event queue (QUEUE_DEPTH entries) fills.
// Synchronous reset clears token state, the halt flag and the queue.
module c_token_classifier #(
  parameter int QUEUE_DEPTH = ctc_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic       last
);
  import ctc_pkg::*;

  event_push_t push_ev;
  event_head_t head;
  logic        take;
  logic        accept;

  assign accept = push && !full;

  ctc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .ch           (ch),
    .end_of_input (end_of_input),
    .push_ev      (push_ev)
  );

  ctc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_ev (push_ev),
    .take    (take),
    .head    (head),
    .full    (full)
  );

  ctc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .take  (take),
    .pop   (pop),
    .empty (empty),
    .kind  (kind),
    .last  (last)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for c_token_classifier: character stream in, token kinds out.
// Depends on ctc_pkg and the c_token_classifier RTL; carries its own lexer model and
// compares every popped result against it.
module testbench;
  import ctc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INT, ST_INTDOT, ST_DOT, ST_DOTFRAC, ST_OP, ST_IDENT, ST_BAD
  } lex_state_e;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } lex_result_t;

  // One directed transaction; typed rows carry their own expected results.
  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
    logic       typed;
    logic [1:0] n;
    kind_t      k0;
  } lex_row_t;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_ITEMS    = 1250;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] ch = 8'h00;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  kind_t      kind;
  logic       last;

  // lexer model state
  lex_state_e  tok_phase = ST_IDLE;
  logic [7:0]  tok_first = 8'h00;
  logic [3:0]  tok_len = 4'd0;
  logic [15:0] kw_live = 16'hFFFF;
  logic        lex_halted = 1'b0;
  lex_result_t pred_res [2];
  int          pred_n;

  lex_result_t expected_results [$];
  int          errors = 0;
  int          random_items = 0;
  bit          no_idle = 1'b0;
  bit          hold_off_req = 1'b0;

  c_token_classifier u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .ch(ch),
    .end_of_input(end_of_input), .empty(empty), .pop(pop), .kind(kind), .last(last)
  );

  always #5 clk = ~clk;

  function automatic string keyword_text(int k);
    case (k)
      0:  return "const";
      1:  return "char";
      2:  return "int";
      3:  return "float";
      4:  return "double";
      5:  return "long";
      6:  return "static";
      7:  return "struct";
      8:  return "void";
      9:  return "enum";
      10: return "extern";
      11: return "return";
      12: return "break";
      13: return "typedef";
      14: return "union";
      default: return "goto";
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" ||
           c == "=" || c == "!" || c == "<" || c == ">";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void lex_clear();
    tok_phase = ST_IDLE;
    tok_first = 8'h00;
    tok_len = 4'd0;
    kw_live = 16'hFFFF;
  endfunction

  function automatic kind_t token_kind();
    kind_t kd;
    string w;
    case (tok_phase)
      ST_INT:               kd = K_INTEGER;
      ST_INTDOT, ST_DOTFRAC: kd = K_FLOAT;
      ST_OP:                kd = K_OPERATOR;
      ST_IDENT: begin
        kd = K_IDENT;
        for (int k = 0; k < 16; k++) begin
          w = keyword_text(k);
          if (kw_live[k] && w.len() == tok_len) kd = K_RESERVED;
        end
      end
      default:              kd = K_ERROR;
    endcase
    return kd;
  endfunction

  function automatic void lex_add(logic [7:0] c);
    logic [15:0] keep;
    string       w;
    case (tok_phase)
      ST_IDLE: begin
        tok_first = c;
        if (is_digit(c)) tok_phase = ST_INT;
        else if (c == ".") tok_phase = ST_DOT;
        else if (is_op(c)) tok_phase = ST_OP;
        else if (is_word(c)) tok_phase = ST_IDENT;
        else tok_phase = ST_BAD;
      end
      ST_INT: begin
        if (c == ".") tok_phase = ST_INTDOT;
        else if (!is_digit(c)) tok_phase = ST_BAD;
      end
      ST_INTDOT, ST_DOT, ST_DOTFRAC: begin
        if (is_digit(c)) begin
          if (tok_phase == ST_DOT) tok_phase = ST_DOTFRAC;
        end else begin
          tok_phase = ST_BAD;
        end
      end
      ST_OP: begin
        // only ==, <=, >=, != extend an operator
        if (!(tok_len == 4'd1 && c == "=" && (tok_first == "=" || tok_first == "<" ||
              tok_first == ">" || tok_first == "!")))
          tok_phase = ST_BAD;
      end
      ST_IDENT: begin
        if (!(is_word(c) || is_digit(c))) tok_phase = ST_BAD;
      end
      default: ;
    endcase
    if (tok_phase == ST_IDENT) begin
      keep = '0;
      if (tok_len < MAX_KEYWORD_LEN) begin
        for (int k = 0; k < 16; k++) begin
          w = keyword_text(k);
          if (tok_len < w.len() && w[tok_len] == c) keep[k] = 1'b1;
        end
      end
      kw_live = kw_live & keep;
    end else begin
      kw_live = '0;
    end
    if (tok_len != 4'd15) tok_len = tok_len + 4'd1;
  endfunction

  // Advance the model by one accepted transaction; results land in pred_res.
  function automatic void lex_step(logic [7:0] c, logic e);
    kind_t k;
    pred_n = 0;
    if (lex_halted) return;
    if (e || is_blank(c)) begin
      if (tok_phase == ST_IDLE) return;
      k = token_kind();
      lex_clear();
      if (k == K_ERROR) lex_halted = 1'b1;
      pred_res[0] = {k, 1'b1};
      pred_n = 1;
    end else if (c == ";") begin
      if (tok_phase != ST_IDLE) begin
        k = token_kind();
        lex_clear();
        if (k == K_ERROR) begin
          lex_halted = 1'b1;
          pred_res[0] = {K_ERROR, 1'b1};
          pred_n = 1;
          return;
        end
        pred_res[0] = {k, 1'b0};
        pred_n = 1;
      end
      pred_res[pred_n] = {K_EOS, 1'b1};
      pred_n = pred_n + 1;
    end else begin
      lex_add(c);
    end
  endfunction

  function automatic void queue_predicted();
    for (int i = 0; i < pred_n; i++) expected_results.push_back(pred_res[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] c, input logic e);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    ch <= c;
    end_of_input <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    lex_step(c, e);
    @(negedge clk);
  endtask

  task automatic send_checked(input logic [7:0] c, input logic e);
    send_item(c, e);
    queue_predicted();
    random_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_checked(s[i], 1'b0);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'(r) + "a";
    if (r < 52) return 8'(r - 26) + "A";
    if (r == 52) return "_";
    return 8'(r - 53) + "0";
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'($urandom_range(0, 9)) + "0";
  endfunction

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_checked(digit_char(), 1'b0);
  endtask

  // Well-formed tokens only; a bad one would halt the block for the rest of the run.
  task automatic send_random_token();
    string       w;
    int          n;
    logic [7:0]  op;
    case ($urandom_range(0, 9))
      0, 1: send_text(keyword_text($urandom_range(0, 15)));
      2: begin
        w = keyword_text($urandom_range(0, 15));
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, w.len() - 1);
          for (int i = 0; i < n; i++) send_checked(w[i], 1'b0);
        end else begin
          send_text(w);
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) send_checked(word_char(1'b0), 1'b0);
        end
      end
      3, 4: begin
        // mostly short names, some past the length counter's saturation
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 22) : $urandom_range(1, 6);
        send_checked(word_char(1'b1), 1'b0);
        for (int i = 1; i < n; i++) send_checked(word_char(1'b0), 1'b0);
      end
      5, 6: send_digits($urandom_range(1, 8));
      7: begin
        if ($urandom_range(0, 1)) begin
          send_digits($urandom_range(1, 4));
          send_checked(".", 1'b0);
          send_digits($urandom_range(0, 4));
        end else begin
          send_checked(".", 1'b0);
          send_digits($urandom_range(1, 4));
        end
      end
      default: begin
        case ($urandom_range(0, 7))
          0: op = "+";
          1: op = "-";
          2: op = "*";
          3: op = "/";
          4: op = "=";
          5: op = "!";
          6: op = "<";
          default: op = ">";
        endcase
        send_checked(op, 1'b0);
        if ((op == "=" || op == "!" || op == "<" || op == ">") && $urandom_range(0, 1))
          send_checked("=", 1'b0);
      end
    endcase
  endtask

  task automatic send_separator();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: repeat ($urandom_range(1, 2)) send_checked(blank_char(), 1'b0);
      6, 7: begin
        send_checked(";", 1'b0);
        if ($urandom_range(0, 1)) send_checked(blank_char(), 1'b0);
      end
      8: send_checked(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        send_checked(";", 1'b0);
        send_checked(";", 1'b0);
      end
    endcase
  endtask

  // Stray separators with no token pending; not counted as stimulus.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_item(blank_char(), 1'b0);
      1:       send_item(";", 1'b0);
      default: send_item(8'($urandom_range(0, 255)), 1'b1);
    endcase
    queue_predicted();
  endtask

  function automatic lex_row_t mk_row(logic [7:0] c, logic e, logic typed, int n, kind_t k0);
    lex_row_t r;
    r.c = c;
    r.eoi = e;
    r.typed = typed;
    r.n = 2'(n);
    r.k0 = k0;
    return r;
  endfunction

  // Receiver: random pop, plus one long hold-off to back the block up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lex_result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d last %0b", kind, last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    lex_row_t    rows [$];
    lex_row_t    r;
    lex_result_t err_res;
    bit          hold_done;
    hold_done = 1'b0;

    // end of input with nothing pending, then a bare semicolon
    rows.push_back(mk_row(8'hFF, 1'b1, 1'b1, 0, K_RESERVED));
    rows.push_back(mk_row(";",   1'b0, 1'b1, 1, K_EOS));
    rows.push_back(mk_row("i",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row("n",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row("t",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(" ",   1'b0, 1'b1, 1, K_RESERVED));
    rows.push_back(mk_row("1",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(".",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h09, 1'b0, 1'b1, 1, K_FLOAT));
    rows.push_back(mk_row(".",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row("5",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h0A, 1'b0, 1'b1, 1, K_FLOAT));
    rows.push_back(mk_row("=",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row("=",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(";",   1'b0, 1'b1, 2, K_OPERATOR));
    rows.push_back(mk_row("7",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h00, 1'b1, 1'b1, 1, K_INTEGER));
    rows.push_back(mk_row("x",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h0B, 1'b0, 1'b1, 1, K_IDENT));
    rows.push_back(mk_row("_",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h0C, 1'b0, 1'b1, 1, K_IDENT));
    rows.push_back(mk_row("-",   1'b0, 1'b0, 0, K_RESERVED));
    rows.push_back(mk_row(8'h0D, 1'b0, 1'b1, 1, K_OPERATOR));
    rows.push_back(mk_row(" ",   1'b0, 1'b1, 0, K_RESERVED));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.c, r.eoi);
      if (!r.typed) begin
        queue_predicted();
      end else if (r.n == 2'd1) begin
        expected_results.push_back({r.k0, 1'b1});
      end else if (r.n == 2'd2) begin
        expected_results.push_back({r.k0, 1'b0});
        expected_results.push_back({K_EOS, 1'b1});
      end
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_idle = random_items >= 400 && random_items < 600;
      if (!hold_done && random_items >= 900) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_random_token();
        send_separator();
      end
    end
    no_idle = 1'b0;

    // One bad token closes the run: the block halts on it and stays halted.
    case ($urandom_range(0, 7))
      0:       send_text("@");
      1:       send_text("1.2.3");
      2:       send_text(".");
      3:       send_text("+=");
      4:       send_text("===");
      5:       send_text("ab$");
      6:       send_text("12a");
      default: send_checked(8'hC8, 1'b0);
    endcase
    case ($urandom_range(0, 2))
      0:       send_item(" ", 1'b0);
      1:       send_item(";", 1'b0);
      default: send_item(8'($urandom_range(0, 255)), 1'b1);
    endcase
    err_res = {K_ERROR, 1'b1};
    expected_results.push_back(err_res);

    // anything after the error must produce nothing
    repeat (30) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      queue_predicted();
    end
    push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[c_token_classifier.f]
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_front.sv
hw/rtl/ctc_queue.sv
hw/rtl/ctc_back.sv
hw/rtl/c_token_classifier.sv
tb/testbench.sv
